/* rtl/cpdc_pkg.sv */
// Package for the circulation pump duty control core.
// Holds request codes, register indexes, the configuration struct and reset values.
// No dependencies.
package cpdc_pkg;

   localparam int unsigned TEMP_W = 12;
   localparam int unsigned CNT_W  = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_EVAL   = 2'd1,
      REQ_MANUAL = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIMIT        = 3'd0,
      CSR_HIGH_LIMIT       = 3'd1,
      CSR_RUN_PERIOD       = 3'd2,
      CSR_IDLE_PERIOD      = 3'd3,
      CSR_IDLE_PERIOD_HIGH = 3'd4,
      CSR_NO_SWITCH_PERIOD = 3'd5,
      CSR_OUTPUT_ENABLED   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] low_limit;
      logic signed [TEMP_W-1:0] high_limit;
      logic [CNT_W-1:0]         run_period;
      logic [CNT_W-1:0]         idle_period;
      logic [CNT_W-1:0]         idle_period_high;
      logic [CNT_W-1:0]         no_switch_period;
      logic                     output_enabled;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      low_limit:        12'sd0,
      high_limit:       12'sd0,
      run_period:       16'd60,
      idle_period:      16'd600,
      idle_period_high: 16'd300,
      no_switch_period: 16'd10,
      output_enabled:   1'b0
   };

endpackage

/* rtl/cpdc_if.sv */
// Handshake channels of the circulation pump duty control core.
// Depends on cpdc_pkg for field widths.
interface cpdc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            req_type;
   logic                                  temp_valid;
   logic signed [cpdc_pkg::TEMP_W-1:0]    temperature;
   modport source (output valid, req_type, temp_valid, temperature, input ready);
   modport sink   (input valid, req_type, temp_valid, temperature, output ready);
endinterface

interface cpdc_rsp_if;
   logic valid;
   logic ready;
   logic pump_on;
   logic changed;
   modport source (output valid, pump_on, changed, input ready);
   modport sink   (input valid, pump_on, changed, output ready);
endinterface

interface cpdc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cpdc_pkg::CSR_IDX_W-1:0]     index;
   logic [cpdc_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cpdc_csr.sv */
// Configuration register bank of the circulation pump duty control core.
// Depends on cpdc_pkg and the cpdc_csr_if channel.
module cpdc_csr (
   input  logic              clock,
   input  logic              reset,
   cpdc_csr_if.sink          csr_ch,
   output cpdc_pkg::cfg_type cfg
);
   import cpdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_LOW_LIMIT:        cfg_in.low_limit  = signed'(csr_ch.data[TEMP_W-1:0]);
            CSR_HIGH_LIMIT:       cfg_in.high_limit = signed'(csr_ch.data[TEMP_W-1:0]);
            CSR_RUN_PERIOD:       cfg_in.run_period       = csr_ch.data[CNT_W-1:0];
            CSR_IDLE_PERIOD:      cfg_in.idle_period      = csr_ch.data[CNT_W-1:0];
            CSR_IDLE_PERIOD_HIGH: cfg_in.idle_period_high = csr_ch.data[CNT_W-1:0];
            CSR_NO_SWITCH_PERIOD: cfg_in.no_switch_period = csr_ch.data[CNT_W-1:0];
            CSR_OUTPUT_ENABLED:   cfg_in.output_enabled   = csr_ch.data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/circulation_pump_duty_control_core.sv */
// Top level of the circulation pump duty control core.
// Depends on cpdc_pkg, the channels in cpdc_if.sv and cpdc_csr.
//
//   channel  | dir | moves                          | accepted when
//   req_ch   | in  | req_type, temp_valid, temp.    | req_ch.valid && req_ch.ready
//   rsp_ch   | out | pump_on, changed               | rsp_ch.valid && rsp_ch.ready
//   csr_ch   | in  | index, data                    | csr_ch.valid (ready tied high)
//
// One request per cycle while no result is held: a request is registered in the
// input register, and the decision logic loads the result register and the pump
// state together. An accepted request passes the input register, then the result register.
// A held result stalls the input register; the input register still takes a
// request while empty. Reset clears pump state and counter and loads CFG_RESET.
module circulation_pump_duty_control_core (
   input  logic       clock,
   input  logic       reset,
   cpdc_req_if.sink   req_ch,
   cpdc_rsp_if.source rsp_ch,
   cpdc_csr_if.sink   csr_ch
);
   import cpdc_pkg::*;

   cfg_type cfg;

   cpdc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // input register
   logic                     s1_valid_ff;
   logic [1:0]               s1_type_ff;
   logic                     s1_tvalid_ff;
   logic signed [TEMP_W-1:0] s1_temp_ff;

   // pump state
   logic             pump_running_ff, pump_running_in;
   logic [CNT_W-1:0] secs_ff, secs_in;

   // result register
   logic rsp_valid_ff;
   logic rsp_pump_on_ff, rsp_pump_on_in;
   logic rsp_changed_ff, rsp_changed_in;

   logic s1_adv;
   logic req_take;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff   <= req_ch.req_type;
         s1_tvalid_ff <= req_ch.temp_valid;
         s1_temp_ff   <= req_ch.temperature;
      end
   end

   // decision logic
   logic too_soon, too_cold, too_hot, run_done, idle_done;
   logic switch_now, switch_to;
   logic [CNT_W-1:0] idle_time;

   always_comb begin
      too_soon  = secs_ff < cfg.no_switch_period;
      too_cold  = s1_tvalid_ff && (s1_temp_ff < cfg.low_limit);
      too_hot   = s1_tvalid_ff && (s1_temp_ff > cfg.high_limit);
      idle_time = too_hot ? cfg.idle_period_high : cfg.idle_period;
      run_done  = secs_ff >= cfg.run_period;
      idle_done = secs_ff >= idle_time;

      switch_now = 1'b0;
      switch_to  = pump_running_ff;
      secs_in    = secs_ff;

      case (req_kind_type'(s1_type_ff))
         REQ_TICK: begin
            if (secs_ff != CNT_MAX) begin
               secs_in = secs_ff + 1'b1;
            end
         end
         REQ_EVAL: begin
            if (!too_soon && cfg.output_enabled) begin
               if (too_cold) begin
                  switch_now = pump_running_ff;
                  switch_to  = 1'b0;
               end else if (pump_running_ff) begin
                  switch_now = run_done;
                  switch_to  = 1'b0;
               end else begin
                  switch_now = idle_done;
                  switch_to  = 1'b1;
               end
            end
         end
         REQ_MANUAL: begin
            switch_now = !pump_running_ff;
            switch_to  = 1'b1;
         end
         default: ;  // unused code: report state, change nothing
      endcase

      pump_running_in = pump_running_ff;
      if (switch_now) begin
         pump_running_in = switch_to;
         secs_in         = '0;
      end
      rsp_pump_on_in = pump_running_in;
      rsp_changed_in = switch_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_running_ff <= 1'b0;
         secs_ff         <= '0;
      end else if (s1_adv) begin
         pump_running_ff <= pump_running_in;
         secs_ff         <= secs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pump_on_ff <= rsp_pump_on_in;
         rsp_changed_ff <= rsp_changed_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.pump_on = rsp_pump_on_ff;
   assign rsp_ch.changed = rsp_changed_ff;

   // a switch clears the counter, and the state holds while the result waits
   a_switch_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_changed_ff |-> secs_ff == '0)
      else $error("switch did not clear the seconds counter");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pump_on_ff == pump_running_ff)
      else $error("reported pump state differs from held state");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> $stable(pump_running_ff) && $stable(secs_ff))
      else $error("pump state moved while a result was stalled");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_type_ff))
      else $error("stalled request lost from input register");

endmodule
